FILE: rtl/bcc_pkg.sv
package bcc_pkg;

  // Event codes carried on event_code
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_HOLD   = 2'd3
  } bcc_event_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_GAP      = 2'd1,
    REG_HOLD     = 2'd2,
    REG_LEVEL    = 2'd3
  } bcc_reg_e;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values
  localparam logic [CfgW-1:0] DebounceRst = 16'd20;
  localparam logic [CfgW-1:0] GapRst      = 16'd250;
  localparam logic [CfgW-1:0] HoldRst     = 16'd3000;
  localparam logic            LevelRst    = 1'b1;

  // Press and release times start at all ones
  localparam logic [TimeW-1:0] TimeRst = '1;

endpackage

FILE: rtl/button_click_classifier_unit.sv
// Button click classifier: one event code per button poll.
// Each poll passes through the input register, then the result register.
// Throughput: one poll per clock unless out_stall_i holds a result; the input register
// and the result register let a new poll in while a finished result waits to be taken.
// Reset (rst_ni low, asynchronous) empties both stages, restores register defaults
// and sets the click state to released, times to all ones, single click allowed.
module button_click_classifier_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // poll channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        pin_level_i,
  input  logic [bcc_pkg::TimeW-1:0]   now_ms_i,
  // event channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  event_code_o,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [bcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bcc_pkg::CfgW-1:0]    cfg_data_i
);
  import bcc_pkg::*;

  // configuration registers
  logic [CfgW-1:0] debounce_q, gap_q, hold_q;
  logic            level_cfg_q;

  // input stage
  logic             in_valid_q;
  logic             pin_q;
  logic [TimeW-1:0] now_q;

  // click state
  logic             last_pressed_q, last_pressed_d;
  logic [TimeW-1:0] press_time_q, press_time_d;
  logic [TimeW-1:0] release_time_q, release_time_d;
  logic             dbl_wait_q, dbl_wait_d;
  logic             dbl_on_rel_q, dbl_on_rel_d;
  logic             single_ok_q, single_ok_d;
  logic             ign_rel_q, ign_rel_d;

  // result stage
  logic       out_valid_q;
  bcc_event_e out_event_q, event_d;

  logic advance;
  logic in_take;

  // classify stage moves when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceRst;
      gap_q       <= GapRst;
      hold_q      <= HoldRst;
      level_cfg_q <= LevelRst;
    end else if (cfg_we_i) begin
      case (bcc_reg_e'(cfg_index_i))
        REG_DEBOUNCE: debounce_q  <= cfg_data_i;
        REG_GAP:      gap_q       <= cfg_data_i;
        REG_HOLD:     hold_q      <= cfg_data_i;
        REG_LEVEL:    level_cfg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
  end

  // classification of the registered poll
  logic             is_pressed;
  logic [TimeW-1:0] since_rel, since_press, since_rel_upd, since_press_upd;
  logic [TimeW-1:0] debounce_ext, gap_ext, hold_ext;
  logic             press_edge, rel_edge, rel_taken;

  always_comb begin
    debounce_ext = {{(TimeW-CfgW){1'b0}}, debounce_q};
    gap_ext      = {{(TimeW-CfgW){1'b0}}, gap_q};
    hold_ext     = {{(TimeW-CfgW){1'b0}}, hold_q};
    is_pressed   = (pin_q == level_cfg_q);
    since_rel    = now_q - release_time_q;
    since_press  = now_q - press_time_q;
    press_edge   = is_pressed && !last_pressed_q && (since_rel > debounce_ext);
    rel_edge     = !is_pressed && last_pressed_q && (since_press > debounce_ext);
    rel_taken    = rel_edge && !ign_rel_q;

    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    dbl_wait_d     = dbl_wait_q;
    dbl_on_rel_d   = dbl_on_rel_q;
    single_ok_d    = single_ok_q;
    ign_rel_d      = ign_rel_q;
    event_d        = EV_NONE;

    // debounced edges
    if (press_edge) begin
      press_time_d = now_q;
      ign_rel_d    = 1'b0;
      single_ok_d  = 1'b1;
      dbl_on_rel_d = (since_rel < gap_ext) && !dbl_on_rel_q && dbl_wait_q;
      dbl_wait_d   = 1'b0;
    end else if (rel_taken) begin
      release_time_d = now_q;
      if (!dbl_on_rel_q) begin
        dbl_wait_d = 1'b1;
      end else begin
        event_d      = EV_DOUBLE;
        dbl_on_rel_d = 1'b0;
        dbl_wait_d   = 1'b0;
        single_ok_d  = 1'b0;
      end
    end

    // elapsed times against the updated stamps (a fresh stamp is zero ago)
    since_rel_upd   = rel_taken ? '0 : since_rel;
    since_press_upd = press_edge ? '0 : since_press;

    // single click once the gap has run out
    if (!is_pressed && (since_rel_upd >= gap_ext) && dbl_wait_d && !dbl_on_rel_d &&
        single_ok_d && (event_d != EV_DOUBLE)) begin
      event_d    = EV_SINGLE;
      dbl_wait_d = 1'b0;
    end

    // hold, repeated every hold period
    if (is_pressed && (since_press_upd >= hold_ext)) begin
      press_time_d = now_q;
      event_d      = EV_HOLD;
      ign_rel_d    = 1'b1;
      dbl_on_rel_d = 1'b0;
      dbl_wait_d   = 1'b0;
    end

    last_pressed_d = is_pressed;
  end

  // click state update on each classified poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pressed_q <= 1'b0;
      press_time_q   <= TimeRst;
      release_time_q <= TimeRst;
      dbl_wait_q     <= 1'b0;
      dbl_on_rel_q   <= 1'b0;
      single_ok_q    <= 1'b1;
      ign_rel_q      <= 1'b0;
    end else if (advance) begin
      last_pressed_q <= last_pressed_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      dbl_wait_q     <= dbl_wait_d;
      dbl_on_rel_q   <= dbl_on_rel_d;
      single_ok_q    <= single_ok_d;
      ign_rel_q      <= ign_rel_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= event_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = out_event_q;

  // checks
  a_ign_clears_dbl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ign_rel_q |-> (!dbl_on_rel_q && !dbl_wait_q))
    else $error("double-click flags set while release is ignored");

  a_dbl_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbl_on_rel_q |-> !dbl_wait_q)
    else $error("double pending and double waiting both set");

  a_double_blocks_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (event_d == EV_DOUBLE)) |=> !single_ok_q)
    else $error("single click still allowed after a double click");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

endmodule
